>>> hdl/keyword_stream_counter_defines.svh
// Assertion macros for the keyword stream counter.
// No dependencies; taken in by the modules that carry assertions.
`ifndef KEYWORD_STREAM_COUNTER_DEFINES_SVH
`define KEYWORD_STREAM_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define KSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyword_stream_counter: assertion failed");

// Next-cycle implication, checked outside reset.
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyword_stream_counter: assertion failed");

`else

`define KSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/kwsc_pkg.sv
// Shared types and constants of the keyword stream counter: keyword table,
// field widths and the controller-to-datapath command bundle. No dependencies.
`default_nettype none

package kwsc_pkg;

    localparam int CH_W     = 8;   // text byte
    localparam int IDX_W    = 4;   // keyword index field
    localparam int CNT_W    = 24;  // occurrence count field
    localparam int LEN_W    = 7;   // letters in the open word
    localparam int KW_SLOTS = 13;  // keywords in the built-in table
    localparam int KW_CHARS = 8;   // longest keyword
    localparam int POS_W    = 3;   // character position within a keyword
    localparam int OUT_W    = 32;  // output tdata, byte aligned

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Sorted keyword table, padded with spaces; chars past the length are never compared.
    localparam logic [0:KW_CHARS-1][7:0] KW_TEXT [KW_SLOTS] = '{
        "auto    ", "break   ", "case    ", "char    ", "const   ",
        "continue", "default ", "define  ", "include ", "unsigned",
        "void    ", "volatile", "while   "
    };

    localparam logic [3:0] KW_LEN [KW_SLOTS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             byte_acc;  // text byte accepted
        logic             eot_acc;   // end of text accepted
        logic             rpt_load;  // load output register with one count
        logic             rpt_last;  // this load is the last of the report
        logic [IDX_W-1:0] rpt_idx;   // keyword being reported
    } t_ctrl_cmd;

endpackage

`default_nettype wire

>>> hdl/keyword_stream_counter.sv
// Top level of the keyword stream counter: stream ports, controller and datapath.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_dp.
//
//  Channel   | Dir | tdata (low bit up)                 | tuser          | tlast
//  ----------+-----+------------------------------------+----------------+------------
//  s_axis    | in  | [7:0] ch                           | -              | end_of_text
//  m_axis    | out | [3:0] keyword_index, [27:4] occur. | overflow_error | last
//
//  Timing: text bytes stream back to back while in the run state.
//  An end-of-text beat is followed by NUM_KEYWORDS report beats, one a cycle
//  while m_axis is ready; s_axis tready stays low until the last one is loaded
//  into the output register.
//  The single output register lets the next text start while the last beat waits.
//  Reset (synchronous, active low) clears word state, counts and the overflow flag.
//  m_axis backpressure stalls the report; no beat is dropped or repeated.
`default_nettype none

module keyword_stream_counter #(
    parameter int MAX_WORD     = 100,  // word length that flags overflow, 9..127
    parameter int NUM_KEYWORDS = 13    // table entries counted and reported, 1..13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // text in
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [kwsc_pkg::CH_W-1:0]     i_s_axis_tdata,   // [7:0] ch
    input  wire logic                          i_s_axis_tlast,   // end_of_text
    // count report out
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [kwsc_pkg::OUT_W-1:0]    o_m_axis_tdata,   // [3:0] keyword_index,
                                                                 // [27:4] occurrences
    output logic                               o_m_axis_tuser,   // [0] overflow_error
    output logic                               o_m_axis_tlast    // last
);

    kwsc_pkg::t_ctrl_cmd          cmd;
    logic [kwsc_pkg::IDX_W-1:0]   out_idx;
    logic [kwsc_pkg::CNT_W-1:0]   out_cnt;

    // run/report sequencing and the output valid flag
    kwsc_ctrl #(
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // word match, counts and output payload
    kwsc_dp #(
        .MAX_WORD     (MAX_WORD),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_ch    (i_s_axis_tdata),
        .o_idx   (out_idx),
        .o_count (out_cnt),
        .o_ovf   (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {
        {(kwsc_pkg::OUT_W - kwsc_pkg::CNT_W - kwsc_pkg::IDX_W){1'b0}}, out_cnt, out_idx
    };

endmodule

`default_nettype wire

>>> hdl/kwsc_ctrl.sv
// Controller of the keyword stream counter: run/report state machine,
// report index and output valid. Uses kwsc_pkg and the assertion macros.
`default_nettype none

`include "keyword_stream_counter_defines.svh"

module kwsc_ctrl #(
    parameter int NUM_KEYWORDS = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output kwsc_pkg::t_ctrl_cmd     o_cmd
);

    localparam int IW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    typedef enum logic [1:0] {
        S_RUN    = 2'b01,
        S_REPORT = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_vld, n_out_vld;

    logic accept;
    logic load;
    logic idx_last;

    assign o_in_ready  = (r_state == S_RUN);
    assign o_out_valid = r_out_vld;

    assign accept   = i_in_valid && o_in_ready;
    // the output register frees up when empty or when its beat is taken
    assign load     = (r_state == S_REPORT) && (!r_out_vld || i_out_ready);
    assign idx_last = (r_idx == IW'(NUM_KEYWORDS - 1));

    always_comb begin
        o_cmd.byte_acc = accept && !i_in_last;
        o_cmd.eot_acc  = accept && i_in_last;
        o_cmd.rpt_load = load;
        o_cmd.rpt_last = load && idx_last;
        o_cmd.rpt_idx  = kwsc_pkg::IDX_W'(r_idx);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_RUN: begin
                if (accept && i_in_last) begin
                    n_state = S_REPORT;
                    n_idx   = '0;
                end
            end
            S_REPORT: begin
                if (load) begin
                    if (idx_last) begin
                        n_state = S_RUN;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
                n_idx   = '0;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    `KSC_ASSERT_NEXT(a_eot_starts_report, i_clk, i_rst_n, o_cmd.eot_acc, (r_state == S_REPORT) && (r_idx == '0))
    `KSC_ASSERT_NEXT(a_last_ends_report, i_clk, i_rst_n, o_cmd.rpt_last, (r_state == S_RUN) && r_out_vld)
    `KSC_ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n, r_state == S_REPORT, r_idx <= IW'(NUM_KEYWORDS - 1))

endmodule

`default_nettype wire

>>> hdl/kwsc_dp.sv
// Datapath of the keyword stream counter: word tracking, parallel keyword
// match, per-keyword saturating counts and the output register. Uses kwsc_pkg.
`default_nettype none

module kwsc_dp #(
    parameter int MAX_WORD     = 100,
    parameter int NUM_KEYWORDS = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire kwsc_pkg::t_ctrl_cmd           i_cmd,
    input  wire logic [kwsc_pkg::CH_W-1:0]     i_ch,
    output logic      [kwsc_pkg::IDX_W-1:0]    o_idx,
    output logic      [kwsc_pkg::CNT_W-1:0]    o_count,
    output logic                               o_ovf,
    output logic                               o_last
);

    localparam int IW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    logic [kwsc_pkg::LEN_W-1:0] r_word_len, n_word_len;
    logic [NUM_KEYWORDS-1:0]    r_alive, n_alive;
    logic                       r_ovf;
    logic [kwsc_pkg::CNT_W-1:0] r_cnt [NUM_KEYWORDS];

    logic [kwsc_pkg::IDX_W-1:0] r_out_idx;
    logic [kwsc_pkg::CNT_W-1:0] r_out_cnt;
    logic                       r_out_ovf;
    logic                       r_out_last;

    logic                       is_letter;
    logic                       word_open;
    logic                       finish;
    logic                       count_ok;
    logic [NUM_KEYWORDS-1:0]    hit;

    assign is_letter = ((i_ch >= 8'h41) && (i_ch <= 8'h5A)) ||
                       ((i_ch >= 8'h61) && (i_ch <= 8'h7A));
    assign word_open = (r_word_len != '0);

    // a word closes on a separator or at end of text; after overflow only end of text closes it
    assign finish   = i_cmd.eot_acc ||
                      (i_cmd.byte_acc && !r_ovf && !is_letter && word_open);
    assign count_ok = finish && word_open && !r_ovf;
    assign n_word_len = r_word_len + 1'b1;

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            n_alive[k] = r_alive[k] &&
                         (r_word_len < kwsc_pkg::LEN_W'(kwsc_pkg::KW_LEN[k])) &&
                         (kwsc_pkg::KW_TEXT[k][r_word_len[kwsc_pkg::POS_W-1:0]] == i_ch);
            hit[k]     = count_ok && r_alive[k] &&
                         (kwsc_pkg::LEN_W'(kwsc_pkg::KW_LEN[k]) == r_word_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len <= '0;
            r_alive    <= '1;
            r_ovf      <= 1'b0;
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.eot_acc) begin
                r_word_len <= '0;
                r_alive    <= '1;
            end else if (i_cmd.byte_acc && !r_ovf) begin
                if (is_letter) begin
                    r_alive    <= n_alive;
                    r_word_len <= n_word_len;
                    if (n_word_len >= kwsc_pkg::LEN_W'(MAX_WORD)) begin
                        r_ovf <= 1'b1;
                    end
                end else if (word_open) begin
                    r_word_len <= '0;
                    r_alive    <= '1;
                end
            end
            if (i_cmd.rpt_last) begin
                r_ovf <= 1'b0;
            end
            // counts are cleared as they are read out
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (hit[k]) begin
                    if (r_cnt[k] != kwsc_pkg::COUNT_MAX) begin
                        r_cnt[k] <= r_cnt[k] + 1'b1;
                    end
                end else if (i_cmd.rpt_load &&
                             (i_cmd.rpt_idx == kwsc_pkg::IDX_W'(k))) begin
                    r_cnt[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_load) begin
            r_out_idx  <= i_cmd.rpt_idx;
            r_out_cnt  <= r_cnt[i_cmd.rpt_idx[IW-1:0]];
            r_out_ovf  <= r_ovf;
            r_out_last <= i_cmd.rpt_last;
        end
    end

    assign o_idx   = r_out_idx;
    assign o_count = r_out_cnt;
    assign o_ovf   = r_out_ovf;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire
